### rtl/shpf_pkg.sv
// Shared constants, types and helper functions of the shifted Hamming prealign filter.
// No dependencies; every other file of the block refers to this package by scoped names.
package shpf_pkg;

  localparam int MAX_SHIFT  = 8;
  localparam int NUM_SHIFTS = 2 * MAX_SHIFT + 1;

  localparam int BASE_W     = 2;
  localparam int MAXERR_W   = 4;
  localparam int COUNT_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int WIN_W      = 4;   // stored raw mismatch bits per shift
  localparam int SEEN_W     = 2;   // saturating base counter, 0..2

  localparam logic [COUNT_W-1:0]  COUNT_MAX       = {COUNT_W{1'b1}};
  localparam logic [MAXERR_W-1:0] ERR_LIMIT_RESET = MAXERR_W'(2);
  localparam logic                AMEND_RESET     = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ERR_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_AMEND     = CFG_IDX_W'(1);

  typedef logic [BASE_W-1:0] base_t;
  typedef logic [2:0]        col_t;   // amended bits at window index 2, 1, 0

  typedef struct packed {
    logic adv;     // an item is accepted this cycle
    logic clr;     // the accepted item closes the sequence
    logic amend;   // amend short zero runs
  } ctrl_t;

  // Amended bits of a 5-bit window (bit 0 newest) at indexes 2, 1 and 0.
  // Bits outside the window count as matches.
  function automatic col_t amend_col(input logic [4:0] v, input logic amend);
    col_t c;
    if (amend) begin
      c[2] = v[2] | (v[3] & (v[1] | v[0])) | (v[4] & v[1]);
      c[1] = v[1] | (v[2] & v[0]) | (v[3] & v[0]);
      c[0] = v[0];
    end else begin
      c = v[2:0];
    end
    return c;
  endfunction

endpackage

### rtl/shpf_in_if.sv
// Input channel of the prealign filter: one base pair per item with a last mark.
// Depends on shpf_pkg for the base code type.
interface shpf_in_if;
  logic              valid;
  logic              ready;
  shpf_pkg::base_t   read_base;
  shpf_pkg::base_t   ref_base;
  logic              last_base;

  modport source (output valid, read_base, ref_base, last_base, input ready);
  modport sink   (input valid, read_base, ref_base, last_base, output ready);
endinterface

### rtl/shpf_out_if.sv
// Result channel of the prealign filter: verdict and mismatch count per sequence.
// Depends on shpf_pkg for the count width.
interface shpf_out_if;
  logic                              valid;
  logic                              ready;
  logic                              accept;
  logic [shpf_pkg::COUNT_W-1:0]      mismatch_count;

  modport source (output valid, accept, mismatch_count, input ready);
  modport sink   (input valid, accept, mismatch_count, output ready);
endinterface

### rtl/shpf_lane.sv
// One shift vector: window of recent raw mismatch bits and its amended column.
// Depends on shpf_pkg (ctrl_t, col_t, amend_col).
module shpf_lane (
  input  logic           clk,
  input  logic           rst_n,
  input  shpf_pkg::ctrl_t ctrl,
  input  logic           raw_bit,
  output shpf_pkg::col_t col
);

  logic [shpf_pkg::WIN_W-1:0] win_r;
  logic [shpf_pkg::WIN_W-1:0] win_nxt;
  logic [4:0]                 full_win;

  assign full_win = {win_r, raw_bit};
  assign col      = shpf_pkg::amend_col(full_win, ctrl.amend);

  always_comb begin
    win_nxt = win_r;
    if (ctrl.adv) begin
      win_nxt = ctrl.clr ? '0 : full_win[shpf_pkg::WIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

endmodule

### rtl/shpf_cell.sv
// Chain cell for one lag: holds a read and a reference base of the history,
// hands them on to the next cell, and keeps the plus and minus shift lanes.
// Depends on shpf_pkg and shpf_lane.
module shpf_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  shpf_pkg::ctrl_t  ctrl,
  input  shpf_pkg::base_t  read_in,
  input  shpf_pkg::base_t  ref_in,
  input  logic             have_in,
  input  shpf_pkg::base_t  cur_read,
  input  shpf_pkg::base_t  cur_ref,
  output shpf_pkg::base_t  read_out,
  output shpf_pkg::base_t  ref_out,
  output logic             have_out,
  output shpf_pkg::col_t   col_plus,
  output shpf_pkg::col_t   col_minus
);

  shpf_pkg::base_t read_r, ref_r;
  logic            have_r, have_nxt;
  logic            raw_plus, raw_minus;

  // Held bases only count once a base has reached this lag.
  assign raw_plus  = have_r & (read_r != cur_ref);
  assign raw_minus = have_r & (ref_r != cur_read);

  always_comb begin
    have_nxt = have_r;
    if (ctrl.adv) begin
      have_nxt = ctrl.clr ? 1'b0 : have_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      read_r <= read_in;
      ref_r  <= ref_in;
    end
  end

  assign read_out = read_r;
  assign ref_out  = ref_r;
  assign have_out = have_r;

  shpf_lane u_plus (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .raw_bit (raw_plus),
    .col     (col_plus)
  );

  shpf_lane u_minus (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .raw_bit (raw_minus),
    .col     (col_minus)
  );

endmodule

### rtl/shpf_result.sv
// Running mismatch count per sequence and a two-entry result queue
// (output register plus skid). Depends on shpf_pkg and shpf_out_if.
module shpf_result (
  input  logic                             clk,
  input  logic                             rst_n,
  input  shpf_pkg::ctrl_t                  ctrl,
  input  shpf_pkg::col_t                   col_all,
  input  logic [shpf_pkg::MAXERR_W-1:0]    err_limit,
  output logic                             in_ready,
  shpf_out_if.source                       out_ch
);

  localparam int SUM_W = shpf_pkg::COUNT_W + 1;

  logic [shpf_pkg::COUNT_W-1:0] ones_r, ones_nxt;
  logic [shpf_pkg::SEEN_W-1:0]  seen_r, seen_nxt;
  logic [1:0]                   inc;
  logic [SUM_W-1:0]             sum;
  logic [shpf_pkg::COUNT_W-1:0] sum_sat;
  logic                         verdict;
  logic                         push, pop;

  logic                         hv_r, hv_nxt, sv_r, sv_nxt;
  logic                         ha_r, ha_nxt, sa_r, sa_nxt;
  logic [shpf_pkg::COUNT_W-1:0] hc_r, hc_nxt, sc_r, sc_nxt;

  // Column 2 is due once two bases are in; columns 1 and 0 flush on the last base.
  always_comb begin
    inc = {1'b0, col_all[2] & (seen_r >= shpf_pkg::SEEN_W'(2))};
    if (ctrl.clr) begin
      inc = inc + {1'b0, col_all[1] & (seen_r >= shpf_pkg::SEEN_W'(1))}
                + {1'b0, col_all[0]};
    end
    sum     = {1'b0, ones_r} + SUM_W'(inc);
    sum_sat = sum[shpf_pkg::COUNT_W] ? shpf_pkg::COUNT_MAX : sum[shpf_pkg::COUNT_W-1:0];
    verdict = (sum_sat <= shpf_pkg::COUNT_W'(err_limit));
  end

  always_comb begin
    ones_nxt = ones_r;
    seen_nxt = seen_r;
    if (ctrl.adv) begin
      if (ctrl.clr) begin
        ones_nxt = '0;
        seen_nxt = '0;
      end else begin
        ones_nxt = sum_sat;
        if (seen_r != shpf_pkg::SEEN_W'(2)) begin
          seen_nxt = seen_r + shpf_pkg::SEEN_W'(1);
        end
      end
    end
  end

  assign push     = ctrl.adv & ctrl.clr;
  assign pop      = hv_r & out_ch.ready;
  assign in_ready = ~sv_r;

  always_comb begin
    hv_nxt = hv_r;
    ha_nxt = ha_r;
    hc_nxt = hc_r;
    sv_nxt = sv_r;
    sa_nxt = sa_r;
    sc_nxt = sc_r;
    if (!hv_r || pop) begin
      if (sv_r) begin
        // promote the skid entry; no push can arrive while the skid is full
        hv_nxt = 1'b1;
        ha_nxt = sa_r;
        hc_nxt = sc_r;
        sv_nxt = 1'b0;
      end else begin
        hv_nxt = push;
        ha_nxt = verdict;
        hc_nxt = sum_sat;
      end
    end else if (push) begin
      sv_nxt = 1'b1;
      sa_nxt = verdict;
      sc_nxt = sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ones_r <= '0;
      seen_r <= '0;
      hv_r   <= 1'b0;
      sv_r   <= 1'b0;
    end else begin
      ones_r <= ones_nxt;
      seen_r <= seen_nxt;
      hv_r   <= hv_nxt;
      sv_r   <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ha_r <= ha_nxt;
    hc_r <= hc_nxt;
    sa_r <= sa_nxt;
    sc_r <= sc_nxt;
  end

  assign out_ch.valid          = hv_r;
  assign out_ch.accept         = ha_r;
  assign out_ch.mismatch_count = hc_r;

  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> hv_r) else $error("skid entry held without a head entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !sv_r) else $error("result pushed into a full queue");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (ones_r == '0) && (seen_r == '0))
    else $error("count not cleared after last base");

  a_count_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.adv && !ctrl.clr) |=> (ones_r >= $past(ones_r)))
    else $error("running count decreased within a sequence");

endmodule

### rtl/shifted_hamming_prealign_filter_unit.sv
// Top level of the shifted Hamming prealign filter: config registers, the lag chain
// and the result stage. Depends on shpf_pkg, shpf_in_if, shpf_out_if, shpf_lane,
// shpf_cell and shpf_result.
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        read_base[1:0], ref_base[1:0], last_base
//  out_ch    out  valid/ready        accept, mismatch_count[7:0]
//  cfg_*     in   cfg_we (no ready)  cfg_idx[0], cfg_wdata[3:0]
//
// One base pair per cycle while in_ch.ready is high; the result of a sequence reaches
// the output register in the cycle after its last item is accepted, or later while that
// register still waits on out_ch.ready (the result then holds in the skid entry).
// The lag chain advances once per accepted item; only the result queue stalls input.
// Reset (rst_n low, synchronous) clears history, windows, counts and the queue and
// loads an error limit of 2 and amend_enable = 1.
// The result queue holds two results; in_ch.ready drops only while both are held.
module shifted_hamming_prealign_filter_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  shpf_in_if.sink                            in_ch,
  shpf_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [shpf_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [shpf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int NS = shpf_pkg::MAX_SHIFT;

  // Configuration registers.
  logic [shpf_pkg::MAXERR_W-1:0] err_limit_r, err_limit_nxt;
  logic                          amend_r, amend_nxt;

  always_comb begin
    err_limit_nxt = err_limit_r;
    amend_nxt     = amend_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        shpf_pkg::REG_ERR_LIMIT: err_limit_nxt = cfg_wdata[shpf_pkg::MAXERR_W-1:0];
        shpf_pkg::REG_AMEND:     amend_nxt     = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_limit_r <= shpf_pkg::ERR_LIMIT_RESET;
      amend_r     <= shpf_pkg::AMEND_RESET;
    end else begin
      err_limit_r <= err_limit_nxt;
      amend_r     <= amend_nxt;
    end
  end

  // Handshake and shared control.
  logic            in_ready;
  shpf_pkg::ctrl_t ctrl;

  assign in_ch.ready = in_ready;
  assign ctrl.adv    = in_ch.valid & in_ready;
  assign ctrl.clr    = in_ch.last_base;
  assign ctrl.amend  = amend_r;

  // Zero-shift lane compares the current pair directly.
  shpf_pkg::col_t diag_col;

  shpf_lane u_diag (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .raw_bit (in_ch.read_base != in_ch.ref_base),
    .col     (diag_col)
  );

  // Lag chain: entry 0 is the incoming pair, entry j the output of cell j.
  shpf_pkg::base_t rd_chain   [0:NS];
  shpf_pkg::base_t rf_chain   [0:NS];
  logic            have_chain [0:NS];
  shpf_pkg::col_t  col_plus   [1:NS];
  shpf_pkg::col_t  col_minus  [1:NS];
  logic            lag_en     [1:NS];

  assign rd_chain[0]   = in_ch.read_base;
  assign rf_chain[0]   = in_ch.ref_base;
  assign have_chain[0] = 1'b1;

  for (genvar j = 1; j <= NS; j++) begin : g_cell
    shpf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .read_in   (rd_chain[j-1]),
      .ref_in    (rf_chain[j-1]),
      .have_in   (have_chain[j-1]),
      .cur_read  (in_ch.read_base),
      .cur_ref   (in_ch.ref_base),
      .read_out  (rd_chain[j]),
      .ref_out   (rf_chain[j]),
      .have_out  (have_chain[j]),
      .col_plus  (col_plus[j]),
      .col_minus (col_minus[j])
    );
    // Lags beyond the error limit drop out of the AND; beyond MAX_SHIFT none exist.
    assign lag_en[j] = (32'(err_limit_r) >= 32'(j));
  end

  // AND the amended columns over the shifts in use.
  shpf_pkg::col_t col_all;

  always_comb begin
    col_all = diag_col;
    for (int j = 1; j <= NS; j++) begin
      col_all = col_all & (col_plus[j] | {3{~lag_en[j]}})
                        & (col_minus[j] | {3{~lag_en[j]}});
    end
  end

  shpf_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .col_all   (col_all),
    .err_limit (err_limit_r),
    .in_ready  (in_ready),
    .out_ch    (out_ch)
  );

  a_cfg_err_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_idx == shpf_pkg::REG_ERR_LIMIT)) |=>
      (err_limit_r == $past(cfg_wdata[shpf_pkg::MAXERR_W-1:0])))
    else $error("error limit write not taken");

  a_chain_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.adv && ctrl.clr) |=> !have_chain[1])
    else $error("lag chain not cleared after last base");

  a_chain_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.adv && !ctrl.clr) |=> have_chain[1])
    else $error("first cell not loaded after a base");

endmodule
